// ----- rtl/core/aaew_pkg.sv -----
// Shared constants, types and helpers for the antialiased edge walker.
package aaew_pkg;

  localparam int unsigned CoordIntBits  = 10;
  localparam int unsigned CoordFracBits = 8;
  localparam int unsigned CoordW        = CoordIntBits + CoordFracBits;
  localparam int unsigned UpShift       = 16 - CoordFracBits;
  localparam int unsigned NumW          = 64;
  localparam int unsigned DenW          = CoordW + 1;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [1:0] KindPixel = 2'd0;
  localparam logic [1:0] KindFill  = 2'd1;
  localparam logic [1:0] KindIdle  = 2'd2;

  localparam logic ModeLoad    = 1'b0;
  localparam logic ModeAdvance = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [CoordW-1:0] x_start;
    logic [CoordW-1:0] y_start;
    logic [CoordW-1:0] x_end;
    logic [CoordW-1:0] y_end;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] px;
    logic [9:0]  py;
    logic [7:0]  alpha;
    logic        last;
  } rsp_t;

  // Decoded request passed from the front part to the back part.
  typedef struct packed {
    logic              advance;
    logic              refused;
    logic              x_major;
    logic              dir_neg;
    logic              degenerate;
    logic [NumW-1:0]   ival_num;
    logic [NumW-1:0]   grad_num;
    logic [DenW-1:0]   den;
    logic [CoordW-1:0] x_start;
    logic [CoordW-1:0] y_start;
    logic [CoordW-1:0] x_end;
    logic [CoordW-1:0] y_end;
  } cmd_t;

  function automatic logic [7:0] row_alpha(input logic [CoordFracBits-1:0] f);
    logic [CoordFracBits+7:0] p;
    p = {8'd0, f} * (CoordFracBits+8)'(255);
    return p[CoordFracBits +: 8];
  endfunction

endpackage

// ----- rtl/core/aaew_if.sv -----
// Valid/ready channel interface carrying a payload.
interface aaew_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/aaew_front.sv -----
// Front part: accept requests, classify the edge and build division operands.
module aaew_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  aaew_pkg::req_t      req_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output aaew_pkg::cmd_t      cmd_o
);

  localparam int unsigned W = aaew_pkg::CoordW;
  localparam int unsigned F = aaew_pkg::CoordFracBits;
  localparam int unsigned Q = aaew_pkg::QueueDepth;

  aaew_pkg::cmd_t cmd_d;
  aaew_pkg::cmd_t fifo_q [Q];
  logic [0:0] wr_q, rd_q;
  logic [1:0] cnt_q;

  logic signed [W+1:0] x0, y0, x1, y1, dx, dy, adx, h;
  logic signed [2*W+3:0] prod_a, prod_b;
  logic signed [63:0] num_i, num_g;

  always_comb begin
    x0 = {2'b00, req_i.x_start};
    y0 = {2'b00, req_i.y_start};
    x1 = {2'b00, req_i.x_end};
    y1 = {2'b00, req_i.y_end};
    dx = x1 - x0;
    dy = y1 - y0;
    adx = dx[W+1] ? -dx : dx;
    cmd_d = '0;
    cmd_d.advance = (req_i.mode == aaew_pkg::ModeAdvance);
    cmd_d.refused = y1 < y0;
    cmd_d.dir_neg = dx[W+1];
    cmd_d.x_major = adx > dy;
    cmd_d.degenerate = !cmd_d.x_major && (dy == '0);
    cmd_d.x_start = req_i.x_start;
    cmd_d.y_start = req_i.y_start;
    cmd_d.x_end = req_i.x_end;
    cmd_d.y_end = req_i.y_end;
    if (cmd_d.x_major) begin
      h = (W+2)'(1 << (F-1)) - {(W+2-F)'(0), req_i.x_start[F-1:0]};
      prod_a = y0 * dx;
      prod_b = dy * h;
      num_i = 64'(prod_a + prod_b) <<< aaew_pkg::UpShift;
      if (dx[W+1]) num_i = -num_i;
      num_g = 64'(dy) <<< 16;
      cmd_d.den = aaew_pkg::DenW'(adx);
    end else begin
      h = (W+2)'(1 << (F-1)) - {(W+2-F)'(0), req_i.y_start[F-1:0]};
      prod_a = x0 * dy;
      prod_b = dx * h;
      num_i = 64'(prod_a + prod_b) <<< aaew_pkg::UpShift;
      num_g = 64'(dx) <<< 16;
      cmd_d.den = aaew_pkg::DenW'(dy);
    end
    cmd_d.ival_num = num_i;
    cmd_d.grad_num = num_g;
  end

  assign req_ready_o = cnt_q != 2'(Q);
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      fifo_q[wr_q] <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (req_valid_i && req_ready_o) wr_q <= wr_q + 1'b1;
      if (cmd_valid_o && cmd_ready_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + 2'(req_valid_i && req_ready_o) - 2'(cmd_valid_o && cmd_ready_i);
    end
  end

endmodule

// ----- rtl/core/aaew_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module aaew_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [aaew_pkg::NumW-1:0]     num_i,
  input  logic [aaew_pkg::DenW-1:0]     den_i,
  output logic                          done_o,
  output logic [aaew_pkg::NumW-1:0]     quo_o
);

  localparam int unsigned N = aaew_pkg::NumW;
  localparam int unsigned D = aaew_pkg::DenW;

  logic [N-1:0] q_q;
  logic [D:0]   r_q;
  logic [D-1:0] d_q;
  logic         neg_q, busy_q;
  logic [$clog2(N+1)-1:0] cnt_q;
  logic [D:0]   r_sh, r_sub;

  assign r_sh = {r_q[D-1:0], q_q[N-1]};
  assign r_sub = r_sh - {1'b0, d_q};
  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o = neg_q ? -q_q : q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= ($clog2(N+1))'(N);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i[N-1] ? -num_i : num_i;
      neg_q <= num_i[N-1];
      r_q <= '0;
      d_q <= den_i;
    end else if (busy_q && cnt_q != '0) begin
      if (!r_sub[D]) begin
        r_q <= r_sub;
        q_q <= {q_q[N-2:0], 1'b1};
      end else begin
        r_q <= r_sh;
        q_q <= {q_q[N-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/core/aaew_back.sv -----
// Back part: run the slope divisions and walk the edge, one result per advance.
module aaew_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  aaew_pkg::cmd_t      cmd_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output aaew_pkg::rsp_t      rsp_o
);

  localparam int unsigned F = aaew_pkg::CoordFracBits;
  localparam int unsigned W = aaew_pkg::CoordW;

  typedef enum logic [2:0] {StRun, StDivI, StDivG, StFin} st_e;
  typedef enum logic [1:0] {PhIdle, PhPixel, PhFill} ph_e;

  st_e st_q;
  ph_e ph_q;
  logic [31:0] acc_q, grad_q;
  logic signed [12:0] cur_x_q, end_x_q, fill_x_q;
  logic signed [11:0] cur_y_q, end_y_q;
  logic [7:0] pend_q, fill_q, end_fill_q;
  logic dir_neg_q, x_major_q;
  aaew_pkg::cmd_t c_q;
  logic [31:0] ival_q;

  logic div_start, div_done;
  logic [aaew_pkg::NumW-1:0] div_num, quo;
  logic busy_flag_q;

  logic out_full_q;
  aaew_pkg::rsp_t out_q;
  aaew_pkg::rsp_t emit_d;
  logic fire;

  aaew_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i(c_q.den), .done_o(div_done), .quo_o(quo)
  );

  logic can_emit;
  assign can_emit = !out_full_q || rsp_ready_i;
  assign cmd_ready_o = (st_q == StRun) && (!cmd_i.advance || can_emit);
  assign rsp_valid_o = out_full_q;
  assign rsp_o = out_q;
  assign fire = (st_q == StRun) && cmd_valid_i && cmd_ready_o && cmd_i.advance;

  assign div_start = (st_q == StDivI && !div_done && c_q.degenerate == 1'b0 &&
                      !busy_flag_q) || (st_q == StDivG && !busy_flag_q);
  assign div_num = (st_q == StDivI) ? c_q.ival_num : c_q.grad_num;

  // Combinational walk step
  logic [31:0] acc_n;
  logic signed [12:0] row, nx;
  logic [7:0] na;
  logic [7:0] a0, unfill0;
  logic signed [11:0] ny;

  always_comb begin
    acc_n = acc_q + grad_q;
    row = 13'(signed'(acc_n[31:16]));
    na = x_major_q ? 8'((acc_n ^ {32{dir_neg_q}}) >> 8) : 8'(8'd255 - acc_n[15:8]);
    nx = cur_x_q + (dir_neg_q ? -13'sd1 : 13'sd1);
    ny = cur_y_q + 12'sd1;
    a0 = c_q.x_major ? 8'((ival_q ^ {32{c_q.dir_neg}}) >> 8) : 8'(8'd255 - ival_q[15:8]);
    unfill0 = aaew_pkg::row_alpha(c_q.y_start[F-1:0]);
  end

  always_comb begin
    emit_d = '0;
    case (ph_q)
      PhPixel: begin
        emit_d.kind = aaew_pkg::KindPixel;
        emit_d.px = cur_x_q[11:0];
        emit_d.py = cur_y_q[9:0];
        emit_d.alpha = pend_q;
      end
      PhFill: begin
        emit_d.kind = aaew_pkg::KindFill;
        emit_d.px = fill_x_q[11:0];
        emit_d.py = cur_y_q[9:0];
        emit_d.alpha = fill_q;
        emit_d.last = ny > end_y_q;
      end
      default: emit_d.kind = aaew_pkg::KindIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StRun;
      ph_q <= PhIdle;
      busy_flag_q <= 1'b0;
      out_full_q <= 1'b0;
      acc_q <= '0;
      grad_q <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
      end_x_q <= '0;
      end_y_q <= '0;
      fill_x_q <= '0;
      pend_q <= '0;
      fill_q <= '0;
      end_fill_q <= '0;
      dir_neg_q <= 1'b0;
      x_major_q <= 1'b0;
      ival_q <= '0;
      c_q <= '0;
      out_q <= '0;
    end else begin
      if (fire) begin
        out_full_q <= 1'b1;
        out_q <= emit_d;
      end else if (rsp_ready_i) begin
        out_full_q <= 1'b0;
      end
      case (st_q)
        StRun: begin
          if (cmd_valid_i && cmd_ready_o) begin
            if (!cmd_i.advance) begin
              if (cmd_i.refused) begin
                ph_q <= PhIdle;
              end else begin
                c_q <= cmd_i;
                busy_flag_q <= 1'b0;
                st_q <= StDivI;
              end
            end else begin
              case (ph_q)
                PhPixel: begin
                  acc_q <= acc_n;
                  pend_q <= na;
                  if (x_major_q) begin
                    cur_x_q <= nx;
                    if (row != 13'(cur_y_q) ||
                        (dir_neg_q ? (nx <= end_x_q) : (nx > end_x_q))) begin
                      if (!dir_neg_q) fill_x_q <= cur_x_q + 13'sd1;
                      ph_q <= PhFill;
                    end
                  end else begin
                    cur_x_q <= row;
                    ph_q <= PhFill;
                  end
                end
                PhFill: begin
                  cur_y_q <= ny;
                  if (ny > end_y_q) begin
                    ph_q <= PhIdle;
                  end else begin
                    if (ny == end_y_q) begin
                      fill_q <= end_fill_q;
                      pend_q <= (pend_q > 8'(8'd255 - end_fill_q)) ?
                                8'(pend_q - (8'd255 - end_fill_q)) : 8'd0;
                    end else begin
                      fill_q <= 8'd255;
                    end
                    fill_x_q <= cur_x_q + 13'sd1;
                    ph_q <= PhPixel;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        StDivI: begin
          if (c_q.degenerate) begin
            ival_q <= 32'({c_q.x_start, {aaew_pkg::UpShift{1'b0}}});
            grad_q <= '0;
            st_q <= StFin;
          end else if (!busy_flag_q) begin
            busy_flag_q <= 1'b1;
          end else if (div_done) begin
            ival_q <= quo[31:0];
            busy_flag_q <= 1'b0;
            st_q <= StDivG;
          end
        end
        StDivG: begin
          if (!busy_flag_q) begin
            busy_flag_q <= 1'b1;
          end else if (div_done) begin
            grad_q <= quo[31:0];
            busy_flag_q <= 1'b0;
            st_q <= StFin;
          end
        end
        StFin: begin
          acc_q <= ival_q;
          dir_neg_q <= c_q.dir_neg;
          x_major_q <= c_q.x_major;
          fill_q <= 8'(8'd255 - unfill0);
          pend_q <= (a0 > unfill0) ? 8'(a0 - unfill0) : 8'd0;
          end_fill_q <= aaew_pkg::row_alpha(c_q.y_end[F-1:0]);
          cur_x_q <= 13'(c_q.x_start[W-1:F]);
          cur_y_q <= 12'(c_q.y_start[W-1:F]);
          end_x_q <= 13'(c_q.x_end[W-1:F]);
          end_y_q <= 12'(c_q.y_end[W-1:F]);
          fill_x_q <= 13'(c_q.x_start[W-1:F]) + 13'sd1;
          ph_q <= PhPixel;
          st_q <= StRun;
        end
        default: st_q <= StRun;
      endcase
    end
  end

endmodule

// ----- rtl/core/antialiased_edge_walker.sv -----
// Top level of the antialiased edge walker.
// Advance request: queued, then registered at the output; one per cycle unstalled.
// Load request: back part busy for the two slope divisions in the shared
// one-bit-per-cycle divider (none for a point edge); later requests wait in a
// two-entry queue.
// Asynchronous active-low reset clears all walk state and goes idle.
module antialiased_edge_walker (
  input  logic   clk_i,
  input  logic   rst_ni,
  aaew_if.sink   req,
  aaew_if.source rsp
);

  logic           cmd_valid, cmd_ready;
  aaew_pkg::cmd_t cmd;

  aaew_front u_front (
    .clk_i, .rst_ni,
    .req_valid_i(req.valid), .req_ready_o(req.ready), .req_i(req.data),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  aaew_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .rsp_valid_o(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_o(rsp.data)
  );

endmodule

// ----- rtl/core/aaew_checker.sv -----
// Port-level checker for the antialiased edge walker, bound to the top level.
module aaew_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input aaew_pkg::rsp_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response dropped while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_data.kind != 2'd3)
    else $error("bad kind");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.kind == aaew_pkg::KindIdle |->
      rsp_data.px == '0 && rsp_data.alpha == '0 && !rsp_data.last)
    else $error("idle result not zero");

  a_pix_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.kind == aaew_pkg::KindPixel |-> !rsp_data.last)
    else $error("pixel marked last");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !rsp_valid)
    else $error("response after reset");

endmodule

bind antialiased_edge_walker aaew_checker u_aaew_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
